// ===== design/afs_pkg.sv =====
// Shared types and constants for the bitmap aspect-fit scaler.
// No dependencies; every other design file imports this package.
package afs_pkg;

  localparam int LANES       = 8;
  localparam int SRC_ADDR_W  = 18;
  localparam int LANE_CYCLES = 13;
  localparam logic [7:0] MSB_PIX = 8'h80;

  typedef enum logic [2:0] {
    REG_IMG_WIDTH  = 3'd0,
    REG_IMG_HEIGHT = 3'd1,
    REG_BOX_LEFT   = 3'd2,
    REG_BOX_TOP    = 3'd3,
    REG_BOX_WIDTH  = 3'd4,
    REG_BOX_HEIGHT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [9:0] img_width;
    logic [9:0] img_height;
    logic [9:0] box_left;
    logic [8:0] box_top;
    logic [9:0] box_width;
    logic [8:0] box_height;
  } cfg_t;

  typedef struct packed {
    logic        dis;
    logic [9:0]  img_width;
    logic [9:0]  img_height;
    logic [9:0]  dw;
    logic [9:0]  dh;
    logic [10:0] dx0;
    logic [9:0]  dy0;
    logic [7:0]  stride;
  } geom_t;

  typedef struct packed {
    logic                  hit;
    logic [SRC_ADDR_W-1:0] addr;
    logic [2:0]            bsel;
  } lane_res_t;

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_POS, F_START, F_LANE, F_HAND} front_st_t;
  typedef enum logic [1:0] {G_IDLE, G_MUL, G_DIV, G_FIN} geom_st_t;
  typedef enum logic [1:0] {M_IDLE, M_READ, M_DONE} merge_st_t;

endpackage

// ===== design/afs_geom.sv =====
// Draw-size and offset computation from the configuration registers.
// Uses afs_pkg; one bit-serial divider runs after reset and after each write.
module afs_geom (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  afs_pkg::cfg_t  cfg,
  output logic           busy,
  output afs_pkg::geom_t geom
);
  import afs_pkg::*;

  geom_st_t    st_r, st_nxt;
  logic        dis;
  logic        wide;
  logic [19:0] pa, pb;
  logic        wide_r;
  logic [19:0] dq_r;
  logic [9:0]  rem_r;
  logic [9:0]  dvs_r;
  logic [4:0]  it_r;
  logic [10:0] trial;
  logic        ge;
  logic [9:0]  q_dw, q_dh;
  geom_t       geom_r;

  assign dis = (cfg.img_width == 10'd0) || (cfg.img_height == 10'd0) ||
               (cfg.box_width == 10'd0) || (cfg.box_height == 9'd0);
  assign pa    = 20'(cfg.img_width) * 20'(cfg.box_height);
  assign pb    = 20'(cfg.img_height) * 20'(cfg.box_width);
  assign wide  = pa > pb;
  assign trial = {rem_r, dq_r[19]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      G_IDLE: st_nxt = G_IDLE;
      G_MUL:  st_nxt = dis ? G_FIN : G_DIV;
      G_DIV:  if (it_r == 5'd19) st_nxt = G_FIN;
      G_FIN:  st_nxt = G_IDLE;
      default: st_nxt = G_IDLE;
    endcase
    if (start) st_nxt = G_MUL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= G_MUL;
    end else begin
      st_r <= st_nxt;
    end
  end

  // The quotient is below 1024 in both branches, so its low ten bits suffice.
  always_comb begin
    if (wide_r) begin
      q_dw = cfg.box_width;
      q_dh = dq_r[9:0];
    end else begin
      q_dw = dq_r[9:0];
      q_dh = {1'b0, cfg.box_height};
    end
    if (q_dw == 10'd0) q_dw = 10'd1;
    if (q_dh == 10'd0) q_dh = 10'd1;
  end

  always_ff @(posedge clk) begin
    case (st_r)
      G_MUL: begin
        wide_r <= wide;
        dq_r   <= wide ? pb : pa;
        dvs_r  <= wide ? cfg.img_width : cfg.img_height;
        rem_r  <= 10'd0;
        it_r   <= 5'd0;
      end
      G_DIV: begin
        rem_r <= ge ? 10'(trial - {1'b0, dvs_r}) : trial[9:0];
        dq_r  <= {dq_r[18:0], ge};
        it_r  <= it_r + 5'd1;
      end
      G_FIN: begin
        geom_r.dis        <= dis;
        geom_r.img_width  <= cfg.img_width;
        geom_r.img_height <= cfg.img_height;
        geom_r.dw         <= q_dw;
        geom_r.dh         <= q_dh;
        geom_r.dx0        <= 11'(cfg.box_left) + 11'((cfg.box_width - q_dw) >> 1);
        geom_r.dy0        <= 10'(cfg.box_top) + 10'(({1'b0, cfg.box_height} - q_dh) >> 1);
        geom_r.stride     <= 8'((11'(cfg.img_width) + 11'd7) >> 3);
      end
      default: begin
      end
    endcase
  end

  assign busy = (st_r != G_IDLE);
  assign geom = geom_r;

endmodule

// ===== design/afs_lane.sv =====
// One pixel lane: window test, source coordinate division and store address.
// Uses afs_pkg; eight of these run side by side for the pixels of one word.
module afs_lane #(
  parameter int FB_HEIGHT = 480
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [10:0]        x_in,
  input  logic [15:0]        y_in,
  input  afs_pkg::geom_t     geom,
  output afs_pkg::lane_res_t res
);
  import afs_pkg::*;

  logic [3:0]  ph_r;
  logic [10:0] x_r;
  logic [15:0] y_r;
  logic [10:0] rx;
  logic [15:0] ry;
  logic        hit_c;
  logic        hit_r;
  logic [19:0] px_r, py_r;
  logic [9:0]  remx_r, remy_r;
  logic [9:0]  dqx_r, dqy_r;
  logic [10:0] tx, ty;
  logic        gex, gey;
  lane_res_t   res_r;

  assign rx    = x_r - geom.dx0;
  assign ry    = y_r - 16'(geom.dy0);
  assign hit_c = !geom.dis && (y_r < 16'(FB_HEIGHT)) && (x_r >= geom.dx0) &&
                 (y_r >= 16'(geom.dy0)) && (rx < {1'b0, geom.dw}) &&
                 (ry < 16'(geom.dh));
  assign tx  = {remx_r, dqx_r[9]};
  assign ty  = {remy_r, dqy_r[9]};
  assign gex = tx >= {1'b0, geom.dw};
  assign gey = ty >= {1'b0, geom.dh};

  // Phase 1 tests and multiplies, phase 2 loads the dividers, phases 3 to 12
  // produce one quotient bit each and phase 13 forms the store address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= 4'd0;
    end else if (start) begin
      ph_r <= 4'd1;
    end else if (ph_r == 4'd13) begin
      ph_r <= 4'd0;
    end else if (ph_r != 4'd0) begin
      ph_r <= ph_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x_in;
      y_r <= y_in;
    end
    if (ph_r == 4'd1) begin
      hit_r <= hit_c;
      px_r  <= 20'(rx[9:0]) * 20'(geom.img_width);
      py_r  <= 20'(ry[9:0]) * 20'(geom.img_height);
    end else if (ph_r == 4'd2) begin
      remx_r <= px_r[19:10];
      dqx_r  <= px_r[9:0];
      remy_r <= py_r[19:10];
      dqy_r  <= py_r[9:0];
    end else if (ph_r >= 4'd3 && ph_r <= 4'd12) begin
      remx_r <= gex ? 10'(tx - {1'b0, geom.dw}) : tx[9:0];
      dqx_r  <= {dqx_r[8:0], gex};
      remy_r <= gey ? 10'(ty - {1'b0, geom.dh}) : ty[9:0];
      dqy_r  <= {dqy_r[8:0], gey};
    end else if (ph_r == 4'd13) begin
      res_r.hit  <= hit_r;
      res_r.addr <= SRC_ADDR_W'(dqy_r) * SRC_ADDR_W'(geom.stride) +
                    SRC_ADDR_W'(dqx_r[9:3]);
      res_r.bsel <= dqx_r[2:0];
    end
  end

  assign res = res_r;

endmodule

// ===== design/afs_merge.sv =====
// Source bitmap store and merging stage: reads the bit each lane found and
// clears the covered black pixels in the word. Uses afs_pkg.
module afs_merge #(
  parameter  int IMG_STORE_BYTES = 32768,
  localparam int AW = $clog2(IMG_STORE_BYTES)
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       wr_en,
  input  logic [AW-1:0]                              wr_addr,
  input  logic [7:0]                                 wr_data,
  input  logic                                       start,
  input  afs_pkg::lane_res_t [afs_pkg::LANES-1:0]    lanes,
  input  logic [15:0]                                fb_index,
  input  logic [7:0]                                 fb_byte,
  output logic                                       idle,
  output logic                                       reading,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic [15:0]                                out_fb_index,
  output logic [7:0]                                 out_fb_byte
);
  import afs_pkg::*;

  logic [7:0] mem [IMG_STORE_BYTES];

  merge_st_t               st_r, st_nxt;
  lane_res_t [LANES-1:0]   lanes_r;
  logic [15:0]             fidx_r;
  logic [7:0]              byte_r;
  logic [3:0]              rcnt_r;
  logic                    pend_r;
  logic [7:0]              rd_r;
  logic                    ok_r;
  logic [2:0]              bsel_r;
  logic [2:0]              lane_r;
  lane_res_t               cur;
  logic                    out_load;
  logic                    out_valid_r;
  logic [15:0]             out_idx_r;
  logic [7:0]              out_byte_r;

  assign cur      = lanes_r[rcnt_r[2:0]];
  assign out_load = (st_r == M_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      M_IDLE: if (start) st_nxt = M_READ;
      M_READ: if (rcnt_r == 4'd8) st_nxt = M_DONE;
      M_DONE: if (out_load) st_nxt = M_IDLE;
      default: st_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= M_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      pend_r <= (st_r == M_READ) && (rcnt_r < 4'd8);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[cur.addr[AW-1:0]];
  end

  // A read issued in one cycle is applied to the word in the next.
  always_ff @(posedge clk) begin
    if (st_r == M_IDLE && start) begin
      lanes_r <= lanes;
      fidx_r  <= fb_index;
      byte_r  <= fb_byte;
      rcnt_r  <= 4'd0;
    end else if (st_r == M_READ) begin
      rcnt_r <= rcnt_r + 4'd1;
      ok_r   <= cur.hit &&
                ({1'b0, cur.addr} < (SRC_ADDR_W + 1)'(IMG_STORE_BYTES));
      bsel_r <= cur.bsel;
      lane_r <= rcnt_r[2:0];
    end
    if (pend_r && ok_r && rd_r[bsel_r]) begin
      byte_r <= byte_r & ~(MSB_PIX >> lane_r);
    end
    if (out_load) begin
      out_idx_r  <= fidx_r;
      out_byte_r <= byte_r;
    end
  end

  assign idle         = (st_r == M_IDLE);
  assign reading      = (st_r == M_READ);
  assign out_valid    = out_valid_r;
  assign out_fb_index = out_idx_r;
  assign out_fb_byte  = out_byte_r;

endmodule

// ===== design/bitmap_aspect_fit_scaler.sv =====
// A load word writes one byte of the source bitmap. A compose word holds the
// input through the accepting cycle, two states that find the word's first
// pixel position, one that starts the lanes, the run of the eight pixel lanes
// with their ten-step bit-serial dividers, and a handoff that waits for the
// merging stage to be idle; the eight store reads of the merging stage
// overlap the next word, and the result sits in an output register.
// A load waits while those store reads are under way. After reset and after
// every configuration write the draw geometry is recomputed, and no word is
// accepted until it is done.
module bitmap_aspect_fit_scaler #(
  parameter int FB_WIDTH        = 800,
  parameter int FB_HEIGHT       = 480,
  parameter int IMG_STORE_BYTES = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [14:0] in_image_addr,
  input  logic [7:0]  in_image_byte,
  input  logic [15:0] in_fb_index,
  input  logic [7:0]  in_fb_byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_fb_index_out,
  output logic [7:0]  out_fb_byte_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  import afs_pkg::*;

  localparam int AW          = $clog2(IMG_STORE_BYTES);
  localparam int RECIP_SHIFT = 30;
  localparam logic [27:0] RECIP = 28'((64'd1 << RECIP_SHIFT) / FB_WIDTH);

  cfg_t                  cfg_r;
  logic                  cfg_we;
  geom_t                 geom;
  logic                  geo_busy;
  front_st_t             fst_r, fst_nxt;
  logic                  accept_ok;
  logic                  in_acc;
  logic [18:0]           ld_ext;
  logic                  wr_en;
  logic [18:0]           p0_r;
  logic [15:0]           fidx_r;
  logic [7:0]            fbyte_r;
  logic [46:0]           prod_r;
  logic [15:0]           yest;
  logic [18:0]           remv;
  logic [10:0]           x0_r;
  logic [15:0]           y0_r;
  logic [3:0]            lcnt_r;
  logic                  merge_idle;
  logic                  merge_reading;
  logic                  lane_start;
  lane_res_t [LANES-1:0] lane_res;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.img_width  <= 10'd0;
      cfg_r.img_height <= 10'd0;
      cfg_r.box_left   <= 10'd0;
      cfg_r.box_top    <= 9'd0;
      cfg_r.box_width  <= 10'd400;
      cfg_r.box_height <= 9'd480;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMG_WIDTH:  cfg_r.img_width  <= cfg_data;
        REG_IMG_HEIGHT: cfg_r.img_height <= cfg_data;
        REG_BOX_LEFT:   cfg_r.box_left   <= cfg_data;
        REG_BOX_TOP:    cfg_r.box_top    <= cfg_data[8:0];
        REG_BOX_WIDTH:  cfg_r.box_width  <= cfg_data;
        REG_BOX_HEIGHT: cfg_r.box_height <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  afs_geom u_geom (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_we),
    .cfg   (cfg_r),
    .busy  (geo_busy),
    .geom  (geom)
  );

  // A load must not overtake the store reads of an earlier compose word.
  assign accept_ok = !geo_busy && (fst_r == F_IDLE) && (in_req_type || !merge_reading);
  assign in_stall  = !accept_ok;
  assign in_acc    = in_valid && accept_ok;
  assign ld_ext    = {4'd0, in_image_addr};
  assign wr_en     = in_acc && !in_req_type && (ld_ext < 19'(IMG_STORE_BYTES));

  always_comb begin
    fst_nxt = fst_r;
    unique case (fst_r)
      F_IDLE:  if (in_acc && in_req_type) fst_nxt = F_MUL;
      F_MUL:   fst_nxt = F_POS;
      F_POS:   fst_nxt = F_START;
      F_START: fst_nxt = F_LANE;
      F_LANE:  if (lcnt_r == 4'(LANE_CYCLES - 1)) fst_nxt = F_HAND;
      F_HAND:  if (merge_idle) fst_nxt = F_IDLE;
      default: fst_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r <= F_IDLE;
    end else begin
      fst_r <= fst_nxt;
    end
  end

  // Row and column of the word's first pixel by reciprocal multiplication;
  // the estimate is at most one row short, so one correction step fixes it.
  assign yest = prod_r[45:30];
  assign remv = p0_r - 19'(yest) * 19'(FB_WIDTH);

  always_ff @(posedge clk) begin
    if (fst_r == F_IDLE && in_acc && in_req_type) begin
      p0_r    <= {in_fb_index, 3'd0};
      fidx_r  <= in_fb_index;
      fbyte_r <= in_fb_byte_in;
    end
    if (fst_r == F_MUL) prod_r <= 47'(p0_r) * 47'(RECIP);
    if (fst_r == F_POS) begin
      if (remv >= 19'(FB_WIDTH)) begin
        x0_r <= 11'(remv - 19'(FB_WIDTH));
        y0_r <= yest + 16'd1;
      end else begin
        x0_r <= 11'(remv);
        y0_r <= yest;
      end
    end
    if (fst_r == F_START) begin
      lcnt_r <= 4'd0;
    end else if (fst_r == F_LANE) begin
      lcnt_r <= lcnt_r + 4'd1;
    end
  end

  assign lane_start = (fst_r == F_START);

  for (genvar b = 0; b < LANES; b++) begin : g_lane
    logic [11:0] xb;
    logic [10:0] lx;
    logic [15:0] ly;

    assign xb = 12'(x0_r) + 12'(b);
    always_comb begin
      if (xb >= 12'(FB_WIDTH)) begin
        lx = 11'(xb - 12'(FB_WIDTH));
        ly = y0_r + 16'd1;
      end else begin
        lx = xb[10:0];
        ly = y0_r;
      end
    end

    afs_lane #(
      .FB_HEIGHT (FB_HEIGHT)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .start (lane_start),
      .x_in  (lx),
      .y_in  (ly),
      .geom  (geom),
      .res   (lane_res[b])
    );
  end

  afs_merge #(
    .IMG_STORE_BYTES (IMG_STORE_BYTES)
  ) u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (wr_en),
    .wr_addr      (ld_ext[AW-1:0]),
    .wr_data      (in_image_byte),
    .start        (fst_r == F_HAND),
    .lanes        (lane_res),
    .fb_index     (fidx_r),
    .fb_byte      (fbyte_r),
    .idle         (merge_idle),
    .reading      (merge_reading),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_fb_index (out_fb_index_out),
    .out_fb_byte  (out_fb_byte_out)
  );

endmodule

// ===== test/bitmap_aspect_fit_scaler_chk.sv =====
// Checker for the bitmap aspect-fit scaler: watches the word, result and register channels,
// keeps its own copy of the source bitmap and geometry, and compares every result word.
// Depends on afs_pkg for the register index names.
module bitmap_aspect_fit_scaler_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_req_type,
  input  logic [14:0] in_image_addr,
  input  logic [7:0]  in_image_byte,
  input  logic [15:0] in_fb_index,
  input  logic [7:0]  in_fb_byte_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_fb_index_out,
  input  logic [7:0]  out_fb_byte_out,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  output int          errors,
  output int          pending
);
  import afs_pkg::*;

  localparam logic REQ_COMPOSE = 1'b1;
  localparam int FB_W = 800;
  localparam int FB_H = 480;
  localparam int STORE_BYTES = 32768;

  typedef struct packed {
    logic [15:0] fb_index;
    logic [7:0]  fb_byte;
  } fb_word_t;

  logic [7:0] bitmap_copy [STORE_BYTES];
  fb_word_t   composed_q [$];
  logic [9:0] img_w, img_h, left_x, box_w;
  logic [8:0] top_y, box_h;

  // Clears every pixel of the byte that lands on a set source bit of the fitted image.
  function automatic logic [7:0] compose_byte(logic [15:0] idx, logic [7:0] fb);
    int unsigned dw, dh, dx0, dy0, pix, x, y, sx, sy, addr, stride;
    logic [7:0] res;
    res = fb;
    if (img_w == 0 || img_h == 0 || box_w == 0 || box_h == 0) return res;
    if (32'(img_w) * 32'(box_h) > 32'(img_h) * 32'(box_w)) begin
      dw = box_w;
      dh = (img_h * box_w) / img_w;
    end else begin
      dh = box_h;
      dw = (img_w * box_h) / img_h;
    end
    if (dw < 1) dw = 1;
    if (dh < 1) dh = 1;
    dx0 = left_x + (box_w - dw) / 2;
    dy0 = top_y + (box_h - dh) / 2;
    stride = (img_w + 7) / 8;
    for (int b = 0; b < 8; b++) begin
      pix = idx * 8 + b;
      x = pix % FB_W;
      y = pix / FB_W;
      if (y >= FB_H || x < dx0 || y < dy0) continue;
      if (x - dx0 >= dw || y - dy0 >= dh) continue;
      sx = ((x - dx0) * img_w) / dw;
      sy = ((y - dy0) * img_h) / dh;
      addr = sy * stride + sx / 8;
      if (addr < STORE_BYTES && bitmap_copy[addr][sx % 8]) res[7 - b] = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    fb_word_t exp_w;
    if (!rst_n) begin
      img_w = 0; img_h = 0; left_x = 0; top_y = 0; box_w = 400; box_h = 480;
      composed_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_IMG_WIDTH:  img_w = cfg_data;
          REG_IMG_HEIGHT: img_h = cfg_data;
          REG_BOX_LEFT:   left_x = cfg_data;
          REG_BOX_TOP:    top_y = cfg_data[8:0];
          REG_BOX_WIDTH:  box_w = cfg_data;
          REG_BOX_HEIGHT: box_h = cfg_data[8:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_req_type == REQ_COMPOSE)
          composed_q.push_back('{in_fb_index, compose_byte(in_fb_index, in_fb_byte_in)});
        else
          bitmap_copy[in_image_addr] = in_image_byte;
      end
      if (out_valid && !out_stall) begin
        if (composed_q.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected: index %0d byte %02h",
                   $time, out_fb_index_out, out_fb_byte_out);
        end else begin
          exp_w = composed_q.pop_front();
          if (out_fb_index_out !== exp_w.fb_index) begin
            errors++;
            $display("%0t: fb_index_out expected %0d got %0d",
                     $time, exp_w.fb_index, out_fb_index_out);
          end
          if (out_fb_byte_out !== exp_w.fb_byte) begin
            errors++;
            $display("%0t: fb_byte_out expected %02h got %02h (index %0d)",
                     $time, exp_w.fb_byte, out_fb_byte_out, exp_w.fb_index);
          end
        end
      end
    end
    pending = composed_q.size();
  end

endmodule

// ===== test/bitmap_aspect_fit_scaler_tb.sv =====
// Top of the scaler testbench: clock, reset, word and register stimulus, result stalls.
// Depends on afs_pkg, the scaler RTL and bitmap_aspect_fit_scaler_chk.
module bitmap_aspect_fit_scaler_tb;
  import afs_pkg::*;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_COMPOSE = 1'b1;
  localparam int FB_W = 800;
  localparam int FB_H = 480;
  localparam int STORE_BYTES = 32768;
  localparam int CYCLE_LIMIT = 1500000;

  logic        clk, rst_n;
  logic        in_valid, in_stall, in_req_type;
  logic [14:0] in_image_addr;
  logic [7:0]  in_image_byte, in_fb_byte_in, out_fb_byte_out;
  logic [15:0] in_fb_index, out_fb_index_out;
  logic        out_valid, out_stall;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [9:0]  cfg_data;
  int          errors, pending, cycles;
  bit          long_hold;

  bit          loaded [STORE_BYTES];
  int unsigned img_w, img_h, left_x, top_y, box_w, box_h;
  int unsigned draw_w, draw_h, draw_x0, draw_y0;
  bit          drawing;

  bitmap_aspect_fit_scaler dut (.*);
  bitmap_aspect_fit_scaler_chk chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Result side: mostly short stalls, quiet stretches, and one long hold-off on request.
  initial begin
    int r;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(50, 200)) @(posedge clk);
      end else if (r < 65) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (r < 95 ? $urandom_range(1, 4) : $urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  task automatic send_word(logic req, logic [14:0] addr, logic [7:0] data,
                           logic [15:0] idx, logic [7:0] fb);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    gap = r < 60 ? 0 : (r < 95 ? $urandom_range(1, 4) : $urandom_range(15, 50));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_image_addr <= addr;
    in_image_byte <= data;
    in_fb_index   <= idx;
    in_fb_byte_in <= fb;
    if (req == REQ_LOAD) loaded[addr] = 1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    // Loads give no result word, so leave room for the store reads to finish.
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 10'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(int unsigned iw, int unsigned ih, int unsigned bl,
                              int unsigned bt, int unsigned bw, int unsigned bh);
    img_w = iw; img_h = ih; left_x = bl; top_y = bt; box_w = bw; box_h = bh;
    write_reg(REG_IMG_WIDTH, iw);
    write_reg(REG_IMG_HEIGHT, ih);
    write_reg(REG_BOX_LEFT, bl);
    write_reg(REG_BOX_TOP, bt);
    write_reg(REG_BOX_WIDTH, bw);
    write_reg(REG_BOX_HEIGHT, bh);
    drawing = iw != 0 && ih != 0 && bw != 0 && bh != 0;
    if (drawing) begin
      if (iw * bh > ih * bw) begin
        draw_w = bw;
        draw_h = (ih * bw) / iw;
      end else begin
        draw_h = bh;
        draw_w = (iw * bh) / ih;
      end
      if (draw_w < 1) draw_w = 1;
      if (draw_h < 1) draw_h = 1;
      draw_x0 = bl + (bw - draw_w) / 2;
      draw_y0 = bt + (bh - draw_h) / 2;
    end
  endtask

  // A compose word reads up to eight store bytes; every one inside the store that was
  // never loaded gets a load word with random content first.
  task automatic compose(logic [15:0] idx, logic [7:0] fb);
    int unsigned pix, x, y, sx, sy, addr;
    if (drawing) begin
      for (int b = 0; b < 8; b++) begin
        pix = idx * 8 + b;
        x = pix % FB_W;
        y = pix / FB_W;
        if (y >= FB_H || x < draw_x0 || y < draw_y0) continue;
        if (x - draw_x0 >= draw_w || y - draw_y0 >= draw_h) continue;
        sx = ((x - draw_x0) * img_w) / draw_w;
        sy = ((y - draw_y0) * img_h) / draw_h;
        addr = sy * ((img_w + 7) / 8) + sx / 8;
        if (addr < STORE_BYTES && !loaded[addr])
          send_word(REQ_LOAD, 15'(addr), 8'($urandom), 16'($urandom), 8'($urandom));
      end
    end
    send_word(REQ_COMPOSE, 15'($urandom), 8'($urandom), idx, fb);
  endtask

  function automatic logic [15:0] pick_index();
    int r;
    int unsigned x, y, pix;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'($urandom_range(48000, 65535));
    if (r < 18 || !drawing) return 16'($urandom_range(0, 47999));
    x = draw_x0 + $urandom_range(0, draw_w - 1);
    y = draw_y0 + $urandom_range(0, draw_h - 1);
    if (x >= FB_W) x = FB_W - 1;
    if (y >= FB_H) y = FB_H - 1;
    pix = y * FB_W + x;
    return 16'(pix / 8);
  endfunction

  initial begin
    int words;
    int iw, ih, bw, bh;
    rst_n = 1'b0;
    in_valid = 1'b0; in_req_type = REQ_LOAD; in_image_addr = '0; in_image_byte = '0;
    in_fb_index = '0; in_fb_byte_in = '0;
    cfg_valid = 1'b0; cfg_index = REG_IMG_WIDTH; cfg_data = '0;
    long_hold = 0;
    img_w = 0; img_h = 0; left_x = 0; top_y = 0; box_w = 400; box_h = 480;
    drawing = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry has a zero-sized image, so every byte comes back untouched.
    send_word(REQ_LOAD, 15'd0, 8'hFF, 16'hFFFF, 8'h00);
    send_word(REQ_LOAD, 15'h7FFF, 8'h00, 16'h0000, 8'hFF);
    compose(16'd0, 8'hFF);
    compose(16'd47999, 8'h00);
    compose(16'hFFFF, 8'hA5);
    drain();

    // Small image at the box corner, plus rows past the screen bottom.
    set_geometry(8, 4, 0, 0, 16, 8);
    compose(16'd0, 8'hFF);
    compose(16'd1, 8'hFF);
    compose(16'd100, 8'hFF);
    compose(16'd700, 8'h5A);
    compose(16'd1500, 8'hFF);
    compose(16'd48000, 8'hFF);
    compose(16'hFFFF, 8'hFF);
    drain();
    set_geometry(1023, 1023, 0, 0, 800, 480);
    compose(16'd30, 8'hFF);
    compose(16'd47999, 8'hFF);
    compose(16'd24000, 8'h00);
    drain();
    set_geometry(1, 1, 799, 479, 800, 480);
    compose(16'd47999, 8'hFF);
    compose(16'd47900, 8'hFF);
    drain();

    words = 0;
    for (int phase = 0; phase < 14; phase++) begin
      case (phase)
        0: set_geometry(1023, 1, 0, 0, 800, 480);
        1: set_geometry(1, 1023, 5, 3, 800, 480);
        2: set_geometry(12, 9, 100, 50, 0, 100);
        3: set_geometry(12, 9, 100, 50, 100, 0);
        4: set_geometry(1023, 1023, 799, 479, 1023, 511);
        5: set_geometry(0, 17, 0, 0, 64, 64);
        default: begin
          iw = $urandom_range(0, 99) < 85 ? $urandom_range(1, 48) : $urandom_range(1, 1023);
          ih = $urandom_range(0, 99) < 85 ? $urandom_range(1, 48) : $urandom_range(1, 1023);
          bw = $urandom_range(1, 800);
          bh = $urandom_range(1, 480);
          set_geometry(iw, ih, $urandom_range(0, 799), $urandom_range(0, 479), bw, bh);
        end
      endcase
      if (phase == 7) long_hold = 1;
      for (int n = 0; n < 110; n++) begin
        if ($urandom_range(0, 99) < 12)
          send_word(REQ_LOAD, 15'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
        else
          compose(pick_index(), 8'($urandom));
        words++;
      end
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
